// ===== design/isu_pkg.sv =====
// Shared constants, codes, types and neighbor table of the Ising update block.
`timescale 1ns / 1ps

package isu_pkg;

  // Store and lattice limits
  localparam int SPIN_DEPTH = 4096;
  localparam int MAX_SIDE   = 64;
  localparam int ADDR_W     = $clog2(SPIN_DEPTH);

  // Field widths
  localparam int SITE_W     = 12;
  localparam int SIDE_W     = 7;
  localparam int LEVEL_W    = 16;
  localparam int MODE_W     = 2;
  localparam int ACT_W      = 2;
  localparam int PROD_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int SQ_W      = 2 * SIDE_W;
  localparam int CUBE_W    = 3 * SIDE_W;
  localparam int NB_MAX    = 6;
  localparam int NB_W      = $clog2(NB_MAX + 1);
  localparam int LVL_IDX_W = $clog2(NB_MAX);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_UPDATE = 2'd2
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    LAT_SQUARE     = 2'd0,
    LAT_HONEYCOMB  = 2'd1,
    LAT_TRIANGULAR = 2'd2,
    LAT_CUBIC      = 2'd3
  } lattice_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_SIDE   = 3'd1,
    REG_LEVEL1 = 3'd2,
    REG_LEVEL2 = 3'd3,
    REG_LEVEL3 = 3'd4,
    REG_LEVEL4 = 3'd5,
    REG_LEVEL5 = 3'd6,
    REG_LEVEL6 = 3'd7
  } cfg_reg_e;

  // Per-axis step of one neighbor
  typedef enum logic [1:0] {
    STEP_ZERO  = 2'd0,
    STEP_PLUS  = 2'd1,
    STEP_MINUS = 2'd2
  } step_e;

  typedef struct packed {
    step_e dc;
    step_e dr;
    step_e dh;
  } nb_dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CUBE,
    ST_CHECK,
    ST_READ,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_NB_RD,
    ST_NB_GET,
    ST_DECIDE,
    ST_RESULT
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [SITE_W-1:0] dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SITE_W-1:0] quot;
    logic [SIDE_W-1:0] rem;
  } div_rsp_t;

  // Neighbor count per lattice
  function automatic logic [NB_W-1:0] nb_count(input lattice_e mode);
    logic [NB_W-1:0] n;
    case (mode)
      LAT_SQUARE:    n = NB_W'(4);
      LAT_HONEYCOMB: n = NB_W'(3);
      default:       n = NB_W'(6);
    endcase
    return n;
  endfunction

  // Direction of neighbor k; odd selects the honeycomb vertical bond
  function automatic nb_dir_t nb_dir(input lattice_e mode, input logic [NB_W-1:0] k,
                                     input logic odd);
    nb_dir_t d;
    d.dc = STEP_ZERO;
    d.dr = STEP_ZERO;
    d.dh = STEP_ZERO;
    case (k)
      3'd0: d.dc = STEP_PLUS;
      3'd1: d.dc = STEP_MINUS;
      3'd2: begin
        if (mode == LAT_HONEYCOMB) d.dr = odd ? STEP_PLUS : STEP_MINUS;
        else d.dr = STEP_MINUS;
      end
      3'd3: begin
        if (mode == LAT_TRIANGULAR) begin
          d.dr = STEP_MINUS;
          d.dc = STEP_PLUS;
        end else begin
          d.dr = STEP_PLUS;
        end
      end
      3'd4: begin
        if (mode == LAT_CUBIC) d.dh = STEP_PLUS;
        else d.dr = STEP_PLUS;
      end
      3'd5: begin
        if (mode == LAT_CUBIC) begin
          d.dh = STEP_MINUS;
        end else begin
          d.dr = STEP_PLUS;
          d.dc = STEP_MINUS;
        end
      end
      default: d.dc = STEP_ZERO;
    endcase
    return d;
  endfunction

endpackage

// ===== design/isu_ram.sv =====
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module isu_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
  end

  // Read port, registered; holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/isu_div.sv =====
// Restoring divider, one quotient bit per cycle, for site coordinates.
`timescale 1ns / 1ps

module isu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isu_pkg::div_req_t  req_i,
  output isu_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(isu_pkg::SITE_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [isu_pkg::SITE_W-1:0]  dvd_q, dvd_d;
  logic [isu_pkg::SIDE_W-1:0]  rem_q, rem_d;
  logic [isu_pkg::SIDE_W-1:0]  dvs_q, dvs_d;
  logic [isu_pkg::SIDE_W:0]    shifted;
  logic [isu_pkg::SIDE_W:0]    diff;
  logic                        ge;

  // One restoring step
  always_comb begin
    shifted = {rem_q, dvd_q[isu_pkg::SITE_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  // Next state
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[isu_pkg::SITE_W-2:0], ge};
      rem_d = ge ? diff[isu_pkg::SIDE_W-1:0] : shifted[isu_pkg::SIDE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(isu_pkg::SITE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

  // Never restarted mid-divide
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  // Finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("divider remainder out of range");

endmodule

// ===== design/ising_metropolis_update.sv =====
// Top level: spin lattice store with write, read and Metropolis update actions.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid_i/in_stall_o   action, site, spin_in, random_fraction
//   out_*        output     out_valid_o/out_stall_i spin_out, flipped, neighbour_product, error
//   cfg_*        input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A write passes through the size, cube and check states to the result state, and a
// read passes through the read state as well; a rejected site or lattice size, and an
// unused action, take the write's path. An update (n = 3, 4 or 6 neighbors) runs the
// size check, two 12-step divides by the side length (site index, then its quotient),
// a neighbor read state and a neighbor fetch state per neighbor through the single port
// of the spin memory, then a state to decide and write back and the result state.
// A request is taken only in the idle state, so items never overlap. Reset clears
// control only; spin memory contents stay undefined until written, with no clearing pass.
// A result waits in the output register under out_stall_i while the next
// request is taken; a second result waits until that register empties.
`timescale 1ns / 1ps

module ising_metropolis_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [isu_pkg::ACT_W-1:0]       action_i,
  input  logic [isu_pkg::SITE_W-1:0]      site_i,
  input  logic                            spin_in_i,
  input  logic [isu_pkg::LEVEL_W-1:0]     random_fraction_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            spin_out_o,
  output logic                            flipped_o,
  output logic signed [isu_pkg::PROD_W-1:0] neighbour_product_o,
  output logic                            error_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [isu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [isu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int ADDR_W = isu_pkg::ADDR_W;
  localparam int SIDE_W = isu_pkg::SIDE_W;
  localparam int PROD_W = isu_pkg::PROD_W;
  localparam int NB_W   = isu_pkg::NB_W;

  // Configuration registers
  isu_pkg::lattice_e                mode_q;
  logic [SIDE_W-1:0]                side_q;
  logic [isu_pkg::LEVEL_W-1:0]      level_q [isu_pkg::NB_MAX];

  // Request registers
  logic [isu_pkg::ACT_W-1:0]        act_q;
  logic [isu_pkg::SITE_W-1:0]       site_q;
  logic                             spin_q;
  logic [isu_pkg::LEVEL_W-1:0]      rnd_q;

  // Work registers
  isu_pkg::state_e                  state_q, state_d;
  logic [isu_pkg::SQ_W-1:0]         sq_q;
  logic [isu_pkg::CUBE_W-1:0]       cube_q;
  logic [ADDR_W-1:0]                rowspan_q;
  logic [ADDR_W-1:0]                planespan_q;
  logic [SIDE_W-1:0]                col_q, row_q, plane_q;
  logic                             old_q;
  logic [NB_W-1:0]                  ups_q;
  logic [NB_W-1:0]                  nb_idx_q;

  // Pending result and output register
  logic                             res_spin_q, res_flip_q, res_err_q;
  logic signed [PROD_W-1:0]         res_prod_q;
  logic                             out_valid_q;
  logic                             out_spin_q, out_flip_q, out_err_q;
  logic signed [PROD_W-1:0]         out_prod_q;

  // Memory and divider hookup
  logic                             ram_we, ram_re, ram_wdata;
  logic [ADDR_W-1:0]                ram_addr;
  logic [0:0]                       ram_rdata;
  isu_pkg::div_req_t                div_req;
  isu_pkg::div_rsp_t                div_rsp;

  // Combinational helpers
  logic                             in_acc, slot_free;
  logic                             act_valid, size_err;
  logic [isu_pkg::CUBE_W-1:0]       count_w;
  logic [NB_W-1:0]                  nb_cnt;
  logic [SIDE_W-1:0]                lm1;
  logic                             odd;
  isu_pkg::nb_dir_t                 dir;
  logic [ADDR_W-1:0]                dc_off, dr_off, dh_off, nb_addr;
  logic signed [PROD_W:0]           sum_w;
  logic signed [PROD_W-1:0]         prod_w;
  logic                             pos;
  logic [isu_pkg::LVL_IDX_W-1:0]    lvl_idx;
  logic                             keep;

  isu_ram #(
    .DEPTH (isu_pkg::SPIN_DEPTH),
    .WIDTH (1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  isu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= isu_pkg::LAT_SQUARE;
      side_q <= SIDE_W'(isu_pkg::MAX_SIDE);
      for (int i = 0; i < isu_pkg::NB_MAX; i++) level_q[i] <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (isu_pkg::cfg_reg_e'(cfg_index_i))
        isu_pkg::REG_MODE:   mode_q     <= isu_pkg::lattice_e'(cfg_data_i[isu_pkg::MODE_W-1:0]);
        isu_pkg::REG_SIDE:   side_q     <= cfg_data_i[SIDE_W-1:0];
        isu_pkg::REG_LEVEL1: level_q[0] <= cfg_data_i;
        isu_pkg::REG_LEVEL2: level_q[1] <= cfg_data_i;
        isu_pkg::REG_LEVEL3: level_q[2] <= cfg_data_i;
        isu_pkg::REG_LEVEL4: level_q[3] <= cfg_data_i;
        isu_pkg::REG_LEVEL5: level_q[4] <= cfg_data_i;
        isu_pkg::REG_LEVEL6: level_q[5] <= cfg_data_i;
        default:             mode_q     <= mode_q;
      endcase
    end
  end

  // Lattice size checks
  always_comb begin
    act_valid = (act_q == isu_pkg::ACT_WRITE) || (act_q == isu_pkg::ACT_READ) ||
                (act_q == isu_pkg::ACT_UPDATE);
    count_w   = (mode_q == isu_pkg::LAT_CUBIC) ? cube_q : isu_pkg::CUBE_W'(sq_q);
    size_err  = (side_q < SIDE_W'(2)) || (32'(side_q) > 32'(isu_pkg::MAX_SIDE)) ||
                (32'(count_w) > 32'(isu_pkg::SPIN_DEPTH)) ||
                (isu_pkg::CUBE_W'(site_q) >= count_w);
  end

  // Neighbor address: site plus wrapped column, row and plane offsets
  always_comb begin
    nb_cnt = isu_pkg::nb_count(mode_q);
    lm1    = side_q - SIDE_W'(1);
    odd    = col_q[0] ^ side_q[0] ^ row_q[0];
    dir    = isu_pkg::nb_dir(mode_q, nb_idx_q, odd);
    case (dir.dc)
      isu_pkg::STEP_PLUS:  dc_off = (col_q == lm1) ? ADDR_W'(0) - ADDR_W'(lm1) : ADDR_W'(1);
      isu_pkg::STEP_MINUS: dc_off = (col_q == '0) ? ADDR_W'(lm1) : '1;
      default:             dc_off = '0;
    endcase
    case (dir.dr)
      isu_pkg::STEP_PLUS:  dr_off = (row_q == lm1) ? ADDR_W'(0) - rowspan_q : ADDR_W'(side_q);
      isu_pkg::STEP_MINUS: dr_off = (row_q == '0) ? rowspan_q : ADDR_W'(0) - ADDR_W'(side_q);
      default:             dr_off = '0;
    endcase
    case (dir.dh)
      isu_pkg::STEP_PLUS:  dh_off = (plane_q == lm1) ? ADDR_W'(0) - planespan_q : ADDR_W'(sq_q);
      isu_pkg::STEP_MINUS: dh_off = (plane_q == '0) ? planespan_q : ADDR_W'(0) - ADDR_W'(sq_q);
      default:             dh_off = '0;
    endcase
    nb_addr = ADDR_W'(site_q) + dc_off + dr_off + dh_off;
  end

  // Acceptance decision from the neighbor sum
  always_comb begin
    sum_w   = $signed({1'b0, ups_q, 1'b0}) - $signed({2'b00, nb_cnt});
    prod_w  = old_q ? sum_w[PROD_W-1:0] : PROD_W'(-sum_w);
    pos     = !prod_w[PROD_W-1] && (prod_w != '0);
    lvl_idx = pos ? (prod_w[isu_pkg::LVL_IDX_W-1:0] - isu_pkg::LVL_IDX_W'(1)) : '0;
    keep    = !(pos && (level_q[lvl_idx] < rnd_q));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isu_pkg::ST_IDLE:    if (in_acc) state_d = isu_pkg::ST_SIZE;
      isu_pkg::ST_SIZE:    state_d = isu_pkg::ST_CUBE;
      isu_pkg::ST_CUBE:    state_d = isu_pkg::ST_CHECK;
      isu_pkg::ST_CHECK: begin
        if (!act_valid || size_err || act_q == isu_pkg::ACT_WRITE) state_d = isu_pkg::ST_RESULT;
        else if (act_q == isu_pkg::ACT_READ) state_d = isu_pkg::ST_READ;
        else state_d = isu_pkg::ST_DIV_COL;
      end
      isu_pkg::ST_READ:    state_d = isu_pkg::ST_RESULT;
      isu_pkg::ST_DIV_COL: if (div_rsp.done) state_d = isu_pkg::ST_DIV_ROW;
      isu_pkg::ST_DIV_ROW: if (div_rsp.done) state_d = isu_pkg::ST_NB_RD;
      isu_pkg::ST_NB_RD:   state_d = isu_pkg::ST_NB_GET;
      isu_pkg::ST_NB_GET: begin
        if (nb_idx_q == nb_cnt - NB_W'(1)) state_d = isu_pkg::ST_DECIDE;
        else state_d = isu_pkg::ST_NB_RD;
      end
      isu_pkg::ST_DECIDE:  state_d = isu_pkg::ST_RESULT;
      isu_pkg::ST_RESULT:  if (slot_free) state_d = isu_pkg::ST_IDLE;
      default:             state_d = isu_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake, memory port, divider
  always_comb begin
    in_stall_o       = (state_q != isu_pkg::ST_IDLE);
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_addr         = ADDR_W'(site_q);
    ram_wdata        = spin_q;
    div_req.start    = 1'b0;
    div_req.dividend = (state_q == isu_pkg::ST_DIV_COL) ? div_rsp.quot : site_q;
    div_req.divisor  = side_q;
    case (state_q)
      isu_pkg::ST_CHECK: begin
        if (act_valid && !size_err) begin
          ram_we        = (act_q == isu_pkg::ACT_WRITE);
          ram_re        = (act_q != isu_pkg::ACT_WRITE);
          div_req.start = (act_q == isu_pkg::ACT_UPDATE);
        end
      end
      isu_pkg::ST_DIV_COL: div_req.start = div_rsp.done;
      isu_pkg::ST_NB_RD: begin
        ram_re   = 1'b1;
        ram_addr = nb_addr;
      end
      isu_pkg::ST_DECIDE: begin
        ram_we    = keep;
        ram_wdata = !old_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == isu_pkg::ST_RESULT && slot_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      isu_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_q  <= action_i;
          site_q <= site_i;
          spin_q <= spin_in_i;
          rnd_q  <= random_fraction_i;
        end
      end
      isu_pkg::ST_SIZE: sq_q <= isu_pkg::SQ_W'(side_q) * isu_pkg::SQ_W'(side_q);
      isu_pkg::ST_CUBE: cube_q <= isu_pkg::CUBE_W'(sq_q) * isu_pkg::CUBE_W'(side_q);
      isu_pkg::ST_CHECK: begin
        rowspan_q   <= ADDR_W'(sq_q - isu_pkg::SQ_W'(side_q));
        planespan_q <= ADDR_W'(cube_q - isu_pkg::CUBE_W'(sq_q));
        ups_q       <= '0;
        nb_idx_q    <= '0;
        res_spin_q  <= act_valid && !size_err && (act_q == isu_pkg::ACT_WRITE) && spin_q;
        res_flip_q  <= 1'b0;
        res_prod_q  <= '0;
        res_err_q   <= act_valid && size_err;
      end
      isu_pkg::ST_READ: res_spin_q <= ram_rdata[0];
      isu_pkg::ST_DIV_COL: begin
        old_q <= ram_rdata[0];
        if (div_rsp.done) col_q <= div_rsp.rem;
      end
      isu_pkg::ST_DIV_ROW: begin
        if (div_rsp.done) begin
          row_q   <= div_rsp.rem;
          plane_q <= div_rsp.quot[SIDE_W-1:0];
        end
      end
      isu_pkg::ST_NB_GET: begin
        ups_q    <= ups_q + NB_W'(ram_rdata[0]);
        nb_idx_q <= nb_idx_q + NB_W'(1);
      end
      isu_pkg::ST_DECIDE: begin
        res_spin_q <= old_q ^ keep;
        res_flip_q <= keep;
        res_prod_q <= prod_w;
      end
      isu_pkg::ST_RESULT: begin
        if (slot_free) begin
          out_spin_q <= res_spin_q;
          out_flip_q <= res_flip_q;
          out_prod_q <= res_prod_q;
          out_err_q  <= res_err_q;
        end
      end
      default: ups_q <= ups_q;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign spin_out_o          = out_spin_q;
  assign flipped_o           = out_flip_q;
  assign neighbour_product_o = out_prod_q;
  assign error_o             = out_err_q;

  // Single memory port: never a read and a write in one cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("spin memory read and write collide");

  // A new result only comes from the result state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == isu_pkg::ST_RESULT))
    else $error("result appeared outside result state");

  // Neighbor walk stays within the lattice's neighbor count
  a_nb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isu_pkg::ST_NB_GET) |-> (nb_idx_q < nb_cnt))
    else $error("neighbor index past count");

  // Divider finishes only while the sequencer waits for it
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == isu_pkg::ST_DIV_COL || state_q == isu_pkg::ST_DIV_ROW))
    else $error("divider done out of sequence");

endmodule
